// ===== sv/tok_pkg.sv =====
`default_nettype none

package tok_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_STR,
		MODE_OP
	} mode_t;

	localparam logic [2:0] KIND_NUMBER    = 3'd0;
	localparam logic [2:0] KIND_IDENT     = 3'd1;
	localparam logic [2:0] KIND_MALFORMED = 3'd2;
	localparam logic [2:0] KIND_STRING    = 3'd3;
	localparam logic [2:0] KIND_UNTERM    = 3'd4;
	localparam logic [2:0] KIND_OPERATOR  = 3'd5;
	localparam logic [2:0] KIND_SYMBOL    = 3'd6;

	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	// Result queue depth; pointers wrap modulo this value.
	localparam int unsigned FIFO_DEPTH = 3;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
		logic       last;
		logic [2:0] kind;
		logic       run_last;
	} tok_res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_digit(c) || (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}) ||
			(c == CH_UNDER);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_opchar(input logic [7:0] c);
		return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
	endfunction

	function automatic logic [2:0] word_kind(input logic leads_digit, input logic all_digits);
		logic [2:0] k;
		if (all_digits)
			k = KIND_NUMBER;
		else if (leads_digit)
			k = KIND_MALFORMED;
		else
			k = KIND_IDENT;
		return k;
	endfunction

	function automatic tok_res_t make_res(input logic [7:0] c, input logic first,
		input logic last, input logic [2:0] kind);
		tok_res_t r;
		r.ch       = c;
		r.first    = first;
		r.last     = last;
		r.kind     = last ? kind : KIND_NUMBER;
		r.run_last = 1'b0;
		return r;
	endfunction

	function automatic logic [1:0] ptr_add(input logic [1:0] p, input logic [1:0] n);
		logic [2:0] s;
		s = {1'b0, p} + {1'b0, n};
		if (s >= 3'(FIFO_DEPTH))
			s = s - 3'(FIFO_DEPTH);
		return s[1:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/source_token_splitter.sv =====
// Streaming tokenizer. Source bytes enter on the input channel (byte_in, with
// end_of_text marking the final byte of a text) and token bytes leave on the
// output channel, each with start/end marks, a kind at the token end, and
// run_last on the last result that an input byte caused.
// One byte is held back so that word ends and operator pairs can be decided,
// so a byte's own result is written into the result queue when the later byte
// that closes or extends its token is accepted; a byte that emits at once (symbol,
// closing quote, end of text) has its results queued when it is accepted.
// Each accepted byte yields zero, one or two results, which go into a
// three-entry result queue. Input is taken whenever the queue holds at most
// one result, so with the receiver ready the block takes one byte per cycle,
// except that a byte yielding two results leaves two in the queue and holds
// in_ready low until the receiver takes one of them.
// When the receiver stalls, the queue fills and in_ready drops; the front
// result stays on the output ports until taken.
// Reset clears the queue and returns the tokenizer to idle with nothing held.
`default_nettype none

module source_token_splitter import tok_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] byte_in,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      char_out,
	output logic            token_start,
	output logic            token_end,
	output logic [2:0]      token_kind,
	output logic            run_last
);

	mode_t      mode_q, n_mode, eff_mode;
	logic       held_valid_q, n_held_valid;
	logic [7:0] held_char_q, n_held_char;
	logic       held_first_q, n_held_first;
	logic       leads_digit_q, n_leads_digit;
	logic       all_digits_q, n_all_digits;

	tok_res_t   res_c [2];
	logic [1:0] n_res;
	logic       do_fresh;
	logic [2:0] flush_kind;

	tok_res_t   fifo_q [FIFO_DEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q, count_q;
	logic       accept, pop;
	tok_res_t   head;

	assign accept = in_valid && in_ready;
	assign pop    = out_valid && out_ready;

	always_comb begin
		n_mode        = mode_q;
		n_held_valid  = held_valid_q;
		n_held_char   = held_char_q;
		n_held_first  = held_first_q;
		n_leads_digit = leads_digit_q;
		n_all_digits  = all_digits_q;
		res_c[0]      = '0;
		res_c[1]      = '0;
		n_res         = 2'd0;
		do_fresh      = 1'b0;
		flush_kind    = KIND_SYMBOL;
		eff_mode      = held_valid_q ? mode_q : MODE_IDLE;

		case (eff_mode)
			MODE_WORD: begin
				if (is_word(byte_in)) begin
					res_c[n_res[0]] = make_res(held_char_q, held_first_q, 1'b0, KIND_NUMBER);
					n_res = n_res + 2'd1;
					n_held_char  = byte_in;
					n_held_first = 1'b0;
					n_all_digits = all_digits_q && is_digit(byte_in);
				end else begin
					res_c[n_res[0]] = make_res(held_char_q, held_first_q, 1'b1,
						word_kind(leads_digit_q, all_digits_q));
					n_res = n_res + 2'd1;
					n_mode       = MODE_IDLE;
					n_held_valid = 1'b0;
					n_held_first = 1'b0;
					do_fresh     = 1'b1;
				end
			end
			MODE_STR: begin
				res_c[n_res[0]] = make_res(held_char_q, held_first_q, 1'b0, KIND_NUMBER);
				n_res = n_res + 2'd1;
				if (byte_in == CH_QUOTE) begin
					res_c[n_res[0]] = make_res(byte_in, 1'b0, 1'b1, KIND_STRING);
					n_res = n_res + 2'd1;
					n_mode       = MODE_IDLE;
					n_held_valid = 1'b0;
					n_held_first = 1'b0;
				end else begin
					n_held_char  = byte_in;
					n_held_first = 1'b0;
				end
			end
			MODE_OP: begin
				if (byte_in == CH_EQ) begin
					res_c[n_res[0]] = make_res(held_char_q, 1'b1, 1'b0, KIND_NUMBER);
					n_res = n_res + 2'd1;
					res_c[n_res[0]] = make_res(byte_in, 1'b0, 1'b1, KIND_OPERATOR);
					n_res = n_res + 2'd1;
				end else begin
					res_c[n_res[0]] = make_res(held_char_q, 1'b1, 1'b1, KIND_SYMBOL);
					n_res = n_res + 2'd1;
					do_fresh = 1'b1;
				end
				n_mode       = MODE_IDLE;
				n_held_valid = 1'b0;
				n_held_first = 1'b0;
			end
			default: begin
				do_fresh = 1'b1;
			end
		endcase

		// A byte that starts nothing pending: open a word, literal or operator, or emit it; whitespace emits nothing.
		if (do_fresh) begin
			if (is_word(byte_in)) begin
				n_mode        = MODE_WORD;
				n_held_valid  = 1'b1;
				n_held_char   = byte_in;
				n_held_first  = 1'b1;
				n_leads_digit = is_digit(byte_in);
				n_all_digits  = is_digit(byte_in);
			end else if (byte_in == CH_QUOTE) begin
				n_mode       = MODE_STR;
				n_held_valid = 1'b1;
				n_held_char  = byte_in;
				n_held_first = 1'b1;
			end else if (is_opchar(byte_in)) begin
				n_mode       = MODE_OP;
				n_held_valid = 1'b1;
				n_held_char  = byte_in;
				n_held_first = 1'b1;
			end else if (!is_space(byte_in)) begin
				res_c[n_res[0]] = make_res(byte_in, 1'b1, 1'b1, KIND_SYMBOL);
				n_res = n_res + 2'd1;
			end
		end

		if (end_of_text && n_held_valid) begin
			if (n_mode == MODE_WORD)
				flush_kind = word_kind(n_leads_digit, n_all_digits);
			else if (n_mode == MODE_STR)
				flush_kind = KIND_UNTERM;
			else
				flush_kind = KIND_SYMBOL;
			res_c[n_res[0]] = make_res(n_held_char, n_held_first, 1'b1, flush_kind);
			n_res = n_res + 2'd1;
			n_mode       = MODE_IDLE;
			n_held_valid = 1'b0;
			n_held_first = 1'b0;
		end

		// With one result it sits in slot 0, with two the last is in slot 1.
		if (n_res != 2'd0)
			res_c[n_res[1]].run_last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			held_valid_q  <= 1'b0;
			held_char_q   <= '0;
			held_first_q  <= 1'b0;
			leads_digit_q <= 1'b0;
			all_digits_q  <= 1'b0;
		end else if (accept) begin
			mode_q        <= n_mode;
			held_valid_q  <= n_held_valid;
			held_char_q   <= n_held_char;
			held_first_q  <= n_held_first;
			leads_digit_q <= n_leads_digit;
			all_digits_q  <= n_all_digits;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (n_res != 2'd0))
			fifo_q[wr_ptr_q] <= res_c[0];
		if (accept && (n_res == 2'd2))
			fifo_q[ptr_add(wr_ptr_q, 2'd1)] <= res_c[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept)
				wr_ptr_q <= ptr_add(wr_ptr_q, n_res);
			if (pop)
				rd_ptr_q <= ptr_add(rd_ptr_q, 2'd1);
			count_q <= count_q + (accept ? n_res : 2'd0) - (pop ? 2'd1 : 2'd0);
		end
	end

	// Room for two more results is kept before a new transaction is taken.
	assign in_ready    = (count_q <= 2'd1);
	assign out_valid   = (count_q != 2'd0);
	assign head        = fifo_q[rd_ptr_q];
	assign char_out    = head.ch;
	assign token_start = head.first;
	assign token_end   = head.last;
	assign token_kind  = head.kind;
	assign run_last    = head.run_last;

	a_open_token_is_held: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_IDLE) |-> held_valid_q)
		else $error("token mode open with no held byte");

	a_eot_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && end_of_text) |=> !held_valid_q)
		else $error("held byte survived end of text");

	a_kind_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !token_end) |-> (token_kind == KIND_NUMBER))
		else $error("token kind set on a byte that does not end a token");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (count_q <= 2'd3) && (count_q != 2'd0 || !$past(n_res != 2'd0)
			|| $past(pop)))
		else $error("result queue count inconsistent with writes");

endmodule

`default_nettype wire

// ===== tb/sv/source_token_splitter_tb.sv =====
`timescale 1ns / 1ps

module source_token_splitter_tb;
	import tok_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_BYTES  = 130;
	localparam int TAIL_CYCLES  = 20;

	localparam logic [7:0] BLANK_SP  = 8'h20;
	localparam logic [7:0] BLANK_TAB = 8'h09;
	localparam logic [7:0] BLANK_LF  = 8'h0A;
	localparam logic [7:0] BLANK_VT  = 8'h0B;
	localparam logic [7:0] BLANK_CR  = 8'h0D;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
	} src_byte_t;

	typedef struct {
		logic [7:0] ch;
		logic       start;
		logic       stop;
		logic [2:0] kind;
		logic       last_of_byte;
	} token_mark_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] byte_in = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] char_out;
	logic       token_start;
	logic       token_end;
	logic [2:0] token_kind;
	logic       run_last;

	source_token_splitter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.byte_in     (byte_in),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_out    (char_out),
		.token_start (token_start),
		.token_end   (token_end),
		.token_kind  (token_kind),
		.run_last    (run_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	src_byte_t   source_bytes[$];
	token_mark_t expected_marks[$];
	token_mark_t step_out[0:1];

	// Tokenizer state as the block should hold it.
	mode_t      tok_mode = MODE_IDLE;
	logic       held_valid = 1'b0;
	logic [7:0] held_ch = 8'h00;
	logic       held_first = 1'b0;
	logic       lead_digit = 1'b0;
	logic       only_digits = 1'b0;

	int  send_idle_pct = 0;
	int  stall_pct = 0;
	logic receiver_hold = 1'b0;
	event hold_go;
	logic in_taken = 1'b0;

	int fail_count = 0;
	int cycle_count = 0;
	int bytes_taken = 0;
	int texts_taken = 0;
	int marks_checked = 0;
	int stim_count = 0;
	int kinds_seen[0:7];

	function automatic logic digit_byte(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic alpha_byte(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
	endfunction

	function automatic logic word_byte(input logic [7:0] c);
		return digit_byte(c) || alpha_byte(c);
	endfunction

	function automatic logic blank_byte(input logic [7:0] c);
		return c == BLANK_SP || (c >= BLANK_TAB && c <= BLANK_CR);
	endfunction

	function automatic logic op_byte(input logic [7:0] c);
		return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT;
	endfunction

	function automatic logic [2:0] word_class();
		if (only_digits)
			return KIND_NUMBER;
		if (lead_digit)
			return KIND_MALFORMED;
		return KIND_IDENT;
	endfunction

	task automatic push_mark(input logic [7:0] c, input logic first, input logic last,
		input logic [2:0] kind, inout int n);
		if (n < 2) begin
			step_out[n].ch = c;
			step_out[n].start = first;
			step_out[n].stop = last;
			step_out[n].kind = last ? kind : KIND_NUMBER;
			step_out[n].last_of_byte = 1'b0;
			n++;
		end
	endtask

	task automatic hold_byte(input logic [7:0] c, input logic first);
		held_valid = 1'b1;
		held_ch = c;
		held_first = first;
	endtask

	task automatic drop_held();
		tok_mode = MODE_IDLE;
		held_valid = 1'b0;
		held_first = 1'b0;
	endtask

	task automatic open_token(input logic [7:0] c, inout int n);
		if (word_byte(c)) begin
			tok_mode = MODE_WORD;
			hold_byte(c, 1'b1);
			lead_digit = digit_byte(c);
			only_digits = digit_byte(c);
		end else if (c == CH_QUOTE) begin
			tok_mode = MODE_STR;
			hold_byte(c, 1'b1);
		end else if (op_byte(c)) begin
			tok_mode = MODE_OP;
			hold_byte(c, 1'b1);
		end else if (!blank_byte(c)) begin
			push_mark(c, 1'b1, 1'b1, KIND_SYMBOL, n);
		end
	endtask

	// Works out the token marks that one source byte releases.
	task automatic tokenize_byte(input logic [7:0] c, input logic eot);
		int n;
		logic [2:0] k;
		n = 0;
		if (!held_valid)
			tok_mode = MODE_IDLE;
		case (tok_mode)
			MODE_WORD: begin
				if (word_byte(c)) begin
					push_mark(held_ch, held_first, 1'b0, KIND_NUMBER, n);
					hold_byte(c, 1'b0);
					only_digits = only_digits && digit_byte(c);
				end else begin
					push_mark(held_ch, held_first, 1'b1, word_class(), n);
					drop_held();
					open_token(c, n);
				end
			end
			MODE_STR: begin
				push_mark(held_ch, held_first, 1'b0, KIND_NUMBER, n);
				if (c == CH_QUOTE) begin
					push_mark(c, 1'b0, 1'b1, KIND_STRING, n);
					drop_held();
				end else begin
					hold_byte(c, 1'b0);
				end
			end
			MODE_OP: begin
				if (c == CH_EQ) begin
					push_mark(held_ch, 1'b1, 1'b0, KIND_NUMBER, n);
					push_mark(c, 1'b0, 1'b1, KIND_OPERATOR, n);
					drop_held();
				end else begin
					push_mark(held_ch, 1'b1, 1'b1, KIND_SYMBOL, n);
					drop_held();
					open_token(c, n);
				end
			end
			default: open_token(c, n);
		endcase
		if (eot && held_valid) begin
			if (tok_mode == MODE_WORD)
				k = word_class();
			else if (tok_mode == MODE_STR)
				k = KIND_UNTERM;
			else
				k = KIND_SYMBOL;
			push_mark(held_ch, held_first, 1'b1, k, n);
			drop_held();
		end
		for (int i = 0; i < n; i++) begin
			step_out[i].last_of_byte = (i == n - 1);
			expected_marks = {expected_marks, step_out[i]};
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] want_v,
		input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Input side: prediction at the edge where a transaction completes.
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			tokenize_byte(byte_in, end_of_text);
			bytes_taken++;
			if (end_of_text)
				texts_taken++;
		end
	end

	always @(negedge clk) begin : feed_bytes
		src_byte_t item;
		if (arst_n && (!in_valid || in_taken)) begin
			if (source_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item = source_bytes.pop_front();
				in_valid <= 1'b1;
				byte_in <= item.ch;
				end_of_text <= item.eot;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_ready <= !receiver_hold && ($urandom_range(99) >= stall_pct);
	end

	initial forever begin
		@(hold_go);
		receiver_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_hold = 1'b0;
	end

	always @(posedge clk) begin : take_result
		token_mark_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_marks.size() == 0) begin
				$error("char_out: no result expected, got %0h", char_out);
				fail_count++;
			end else begin
				want = expected_marks.pop_front();
				marks_checked++;
				compare_field("char_out", want.ch, char_out);
				compare_field("token_start", 8'(want.start), 8'(token_start));
				compare_field("token_end", 8'(want.stop), 8'(token_end));
				compare_field("token_kind", 8'(want.kind), 8'(token_kind));
				compare_field("run_last", 8'(want.last_of_byte), 8'(run_last));
				if (want.stop)
					kinds_seen[want.kind]++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic offer(input logic [7:0] c, input logic eot);
		src_byte_t item;
		item.ch = c;
		item.eot = eot;
		source_bytes = {source_bytes, item};
		stim_count++;
	endtask

	function automatic logic [7:0] pick_alpha();
		logic [7:0] c;
		do c = 8'($urandom_range(8'h41, 8'h7A)); while (!alpha_byte(c));
		return c;
	endfunction

	function automatic logic [7:0] pick_blank();
		logic [7:0] c;
		c = 8'($urandom_range(BLANK_TAB, BLANK_CR + 1));
		return (c > BLANK_CR) ? BLANK_SP : c;
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(3))
			0: return CH_EQ;
			1: return CH_BANG;
			2: return CH_LT;
			default: return CH_GT;
		endcase
	endfunction

	function automatic logic [7:0] pick_symbol();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (word_byte(c) || blank_byte(c) || op_byte(c) || c == CH_QUOTE);
		return c;
	endfunction

	// A well-formed text: a run of tokens with random content, ending on
	// the final byte of the text, sometimes inside an open literal.
	task automatic queue_text(input int n_tokens);
		src_byte_t buf_q[$];
		src_byte_t b;
		int len;
		int sel;
		b.eot = 1'b0;
		for (int t = 0; t < n_tokens; t++) begin
			sel = $urandom_range(9);
			len = $urandom_range(1, 6);
			if (sel <= 3) begin
				for (int i = 0; i < len; i++) begin
					case (sel)
						0: b.ch = 8'($urandom_range("0", "9"));
						1: b.ch = (i == 0) ? 8'($urandom_range("0", "9")) :
							($urandom_range(1) ? pick_alpha() : 8'($urandom_range("0", "9")));
						default: b.ch = (i == 0) ? pick_alpha() :
							($urandom_range(1) ? pick_alpha() : 8'($urandom_range("0", "9")));
					endcase
					buf_q = {buf_q, b};
				end
			end else if (sel <= 5) begin
				b.ch = CH_QUOTE;
				buf_q = {buf_q, b};
				for (int i = 0; i < len - 1; i++) begin
					do b.ch = 8'($urandom_range(255)); while (b.ch == CH_QUOTE);
					buf_q = {buf_q, b};
				end
				b.ch = CH_QUOTE;
				buf_q = {buf_q, b};
			end else if (sel == 6) begin
				b.ch = pick_op();
				buf_q = {buf_q, b};
				b.ch = CH_EQ;
				buf_q = {buf_q, b};
			end else if (sel == 7) begin
				b.ch = pick_op();
				buf_q = {buf_q, b};
			end else begin
				b.ch = pick_symbol();
				buf_q = {buf_q, b};
			end
			if ($urandom_range(2) != 0) begin
				b.ch = pick_blank();
				buf_q = {buf_q, b};
			end
		end
		if ($urandom_range(5) == 0) begin
			b.ch = CH_QUOTE;
			buf_q = {buf_q, b};
			repeat ($urandom_range(3)) begin
				do b.ch = 8'($urandom_range(255)); while (b.ch == CH_QUOTE);
				buf_q = {buf_q, b};
			end
		end
		buf_q[buf_q.size() - 1].eot = 1'b1;
		foreach (buf_q[i])
			offer(buf_q[i].ch, buf_q[i].eot);
	endtask

	task automatic queue_noise(input int n_bytes);
		for (int i = 0; i < n_bytes; i++)
			offer(8'($urandom_range(255)), $urandom_range(15) == 0 || i == n_bytes - 1);
	endtask

	task automatic wait_drained();
		while (source_bytes.size() != 0 || in_valid || expected_marks.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input logic with_hold);
		int target;
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		target = stim_count + PHASE_BYTES;
		while (stim_count < target) begin
			if ($urandom_range(9) < 7)
				queue_text($urandom_range(2, 8));
			else
				queue_noise($urandom_range(4, 12));
		end
		if (with_hold)
			-> hold_go;
		wait_drained();
	endtask

	initial begin
		foreach (kinds_seen[i])
			kinds_seen[i] = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Word classes with the edge letters and digits.
		offer("_", 1'b0); offer("z", 1'b0); offer("9", 1'b0); offer("A", 1'b0);
		offer(BLANK_SP, 1'b0);
		offer("0", 1'b0); offer("9", 1'b0); offer(BLANK_TAB, 1'b0);
		offer("7", 1'b0); offer("q", 1'b0); offer(BLANK_LF, 1'b0);
		// Operator pairs back to back, then an unpaired one.
		offer(CH_EQ, 1'b0); offer(CH_EQ, 1'b0); offer(CH_BANG, 1'b0); offer(CH_EQ, 1'b0);
		offer(CH_LT, 1'b0); offer("a", 1'b0);
		// Literal with whitespace kept inside, then high and zero bytes.
		offer(CH_QUOTE, 1'b0); offer(BLANK_VT, 1'b0); offer(CH_QUOTE, 1'b0);
		offer(8'hFF, 1'b0); offer(8'h00, 1'b0);
		// Literal still open at the end of text, then a lone quote as a text.
		offer(CH_QUOTE, 1'b0); offer("x", 1'b1);
		offer(CH_QUOTE, 1'b1);
		wait_drained();

		run_phase(0, 0, 1'b0);
		run_phase(59, 0, 1'b0);
		run_phase(0, 59, 1'b0);
		run_phase(23, 23, 1'b0);
		run_phase(0, 0, 1'b1);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d source bytes in %0d texts through five traffic phases, one long hold-off.",
			bytes_taken, texts_taken);
		$display("Checked %0d token bytes; tokens ended by kind 0..6: %0d %0d %0d %0d %0d %0d %0d",
			marks_checked, kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3],
			kinds_seen[4], kinds_seen[5], kinds_seen[6]);
		if (fail_count == 0 && expected_marks.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
